@@ hdl/kalman_angle_filter_core_defines.svh @@
// Assertion macros shared by the filter core.
`ifndef KALMAN_ANGLE_FILTER_CORE_DEFINES_SVH
`define KALMAN_ANGLE_FILTER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define KAF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define KAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/kaf_pkg.sv @@
`timescale 1ns / 1ps
package kaf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned RegW  = 31;
  localparam int unsigned FracW = 30;

  localparam logic [RegW-1:0] TimeStepRst     = 31'd10737418;
  localparam logic [RegW-1:0] AngleNoiseRst   = 31'd1073742;
  localparam logic [RegW-1:0] BiasNoiseRst    = 31'd3221225;
  localparam logic [RegW-1:0] MeasureNoiseRst = 31'd32212255;
  localparam logic signed [DataW-1:0] BiasRst = 32'sd197;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegTimeStep     = 2'd0;
  localparam logic [1:0] RegAngleNoise   = 2'd1;
  localparam logic [1:0] RegBiasNoise    = 2'd2;
  localparam logic [1:0] RegMeasureNoise = 2'd3;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[DataW-1:0];
  endfunction

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic                    start;
    logic signed [DataW-1:0] num;
    logic signed [DataW:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DataW-1:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/kaf_mul.sv @@
`timescale 1ns / 1ps
module kaf_mul (
  input  logic                            clk_i,
  input  logic signed [kaf_pkg::DataW-1:0] a_i,
  input  logic signed [kaf_pkg::DataW-1:0] b_i,
  output logic signed [kaf_pkg::DataW-1:0] p_o
);
  import kaf_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [65:0] rnd;

  // Registered full product, then round half up and saturate.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign rnd = ($signed({{2{prod_q[63]}}, prod_q}) + 66'sd536870912) >>> FracW;
  assign p_o = sat32(rnd);
endmodule

@@ hdl/kaf_div.sv @@
`timescale 1ns / 1ps
module kaf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kaf_pkg::div_req_t req_i,
  output kaf_pkg::div_rsp_t rsp_o
);
  import kaf_pkg::*;

  // Restoring divider: |num| * 2^30 over a positive 33-bit denominator,
  // one quotient bit a cycle.
  localparam int unsigned NumW = 62;

  logic [NumW-1:0] rem_num_q;
  logic [NumW:0]   quo_q;
  logic [33:0]     part_q;
  logic [32:0]     den_q;
  logic            neg_q;
  logic [5:0]      cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [33:0]     trial;
  logic [33:0]     shifted;
  logic [31:0]     mag;
  logic signed [65:0] sq;

  assign mag     = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
  assign shifted = {part_q[32:0], rem_num_q[NumW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NumW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_num_q <= {mag, 30'd0};
      part_q    <= '0;
      quo_q     <= '0;
      den_q     <= 33'(req_i.den);
      neg_q     <= req_i.num[31];
    end else if (busy_q) begin
      rem_num_q <= {rem_num_q[NumW-2:0], 1'b0};
      if (!trial[33]) begin
        part_q <= trial;
        quo_q  <= {quo_q[NumW-1:0], 1'b1};
      end else begin
        part_q <= shifted;
        quo_q  <= {quo_q[NumW-1:0], 1'b0};
      end
    end
  end

  assign sq = neg_q ? -$signed({3'b000, quo_q}) : $signed({3'b000, quo_q});
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = sat32(sq);
endmodule

@@ hdl/kalman_angle_filter_core.sv @@
`timescale 1ns / 1ps
// One transaction at a time: the input stalls until the result is loaded. Two
// gain divides and ten passes through the shared multiplier make up the work;
// the divides are skipped when the innovation variance is not positive.
// Reset clears the estimates to angle 0, bias 197 and zero covariance, and
// loads the default noise and time-step registers.
`include "kalman_angle_filter_core_defines.svh"
module kalman_angle_filter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [kaf_pkg::DataW-1:0] measured_angle_i,
  input  logic signed [kaf_pkg::DataW-1:0] measured_rate_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [kaf_pkg::DataW-1:0] filtered_angle_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [kaf_pkg::RegW-1:0]        cfg_data_i
);
  import kaf_pkg::*;

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StMul  = 9'b000000010,
    StWait = 9'b000000100,
    StGain = 9'b000001000,
    StDiv  = 9'b000010000,
    StDivW = 9'b000100000,
    StCor  = 9'b001000000,
    StCorW = 9'b010000000,
    StOut  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [RegW-1:0] dt_q, qa_q, qb_q, rm_q;
  logic signed [DataW-1:0] ang_q, bias_q, paa_q, pab_q, pba_q, pbb_q;
  logic signed [DataW-1:0] meas_q, rate_q, t_q, k0_q, k1_q, y_q;
  logic signed [DataW-1:0] out_q;
  logic [3:0] step_q;
  logic       div_sel_q;
  logic       out_load;
  logic signed [DataW-1:0] ma, mb, mp;
  logic signed [DataW:0]   s_w;
  div_req_t div_req;
  div_rsp_t div_rsp;

  kaf_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));
  kaf_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));

  // Multiplier operand select per prediction or correction step.
  always_comb begin
    ma = $signed({1'b0, dt_q});
    mb = rate_q;
    if (state_q == StCor) begin
      case (step_q)
        4'd0: begin ma = k0_q; mb = y_q;   end
        4'd1: begin ma = k1_q; mb = y_q;   end
        4'd2: begin ma = k0_q; mb = paa_q; end
        4'd3: begin ma = k1_q; mb = pab_q; end
        4'd4: begin ma = k1_q; mb = paa_q; end
        default: begin ma = k0_q; mb = pab_q; end
      endcase
    end else begin
      case (step_q)
        4'd0: mb = rate_q;
        4'd1: mb = pbb_q;
        4'd2: mb = rate_q;
        default: mb = $signed({1'b0, qb_q});
      endcase
    end
  end

  assign s_w = $signed({paa_q[31], paa_q}) + $signed({2'b00, rm_q});
  assign div_req.start = (state_q == StDiv);
  assign div_req.num   = div_sel_q ? pba_q : paa_q;
  assign div_req.den   = s_w;

  // The result register is loaded once the previous result has left.
  assign out_load = (state_q == StOut) && (!out_valid_o || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul:  state_d = StWait;
      StWait: state_d = (step_q == 4'd3) ? StGain : StMul;
      StGain: state_d = (s_w > 0) ? StDiv : StCor;
      StDiv:  state_d = StDivW;
      StDivW: if (div_rsp.done) state_d = div_sel_q ? StCor : StDiv;
      StCor:  state_d = StCorW;
      StCorW: state_d = (step_q == 4'd5) ? StOut : StCor;
      StOut:  if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      div_sel_q   <= 1'b0;
      out_valid_o <= 1'b0;
      dt_q <= TimeStepRst; qa_q <= AngleNoiseRst;
      qb_q <= BiasNoiseRst; rm_q <= MeasureNoiseRst;
      ang_q <= '0; bias_q <= BiasRst;
      paa_q <= '0; pab_q <= '0; pba_q <= '0; pbb_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegTimeStep:     dt_q <= cfg_data_i;
          RegAngleNoise:   qa_q <= cfg_data_i;
          RegBiasNoise:    qb_q <= cfg_data_i;
          RegMeasureNoise: rm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) out_valid_o <= 1'b1;
      else if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StIdle: step_q <= '0;
        StWait: begin
          step_q <= (step_q == 4'd3) ? 4'd0 : step_q + 4'd1;
          case (step_q)
            4'd0: ang_q <= sat32(66'(ang_q) + 66'(mp));
            4'd1: begin
              t_q   <= mp;
              pab_q <= sat32(66'(pab_q) - 66'(mp));
              pba_q <= sat32(66'(pba_q) - 66'(mp));
            end
            4'd2: paa_q <= sat32(66'(paa_q) + 66'(mp));
            default: pbb_q <= sat32(66'(pbb_q) + 66'(mp));
          endcase
        end
        StGain: begin
          div_sel_q <= 1'b0;
          k0_q <= '0; k1_q <= '0;
          y_q  <= sat32(66'(meas_q) - 66'(ang_q));
        end
        StDivW: if (div_rsp.done) begin
          if (div_sel_q) k1_q <= div_rsp.quo;
          else k0_q <= div_rsp.quo;
          div_sel_q <= 1'b1;
        end
        StCorW: begin
          step_q <= step_q + 4'd1;
          // The off-diagonal and diagonal terms use the predicted covariance,
          // so pab and paa change only in the last step.
          case (step_q)
            4'd0: ang_q  <= sat32(66'(ang_q) + 66'(mp));
            4'd1: bias_q <= sat32(66'(bias_q) + 66'(mp));
            4'd2: t_q    <= mp;
            4'd3: pbb_q  <= sat32(66'(pbb_q) - 66'(mp));
            4'd4: pba_q  <= sat32(66'(pba_q) - 66'(mp));
            default: begin
              pab_q <= sat32(66'(pab_q) - 66'(mp));
              paa_q <= sat32(66'(paa_q) - 66'(t_q));
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Input capture with the bias-corrected rate; the rate register later holds
  // the inner covariance term, built from the pre-update off-diagonals.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      meas_q <= measured_angle_i;
      rate_q <= sat32(66'(measured_rate_i) - 66'(bias_q));
    end else if (state_q == StWait && step_q == 4'd1) begin
      rate_q <= sat32(66'(mp) - 66'(pab_q) - 66'(pba_q) + 66'(qa_q));
    end
    if (out_load) out_q <= ang_q;
  end

  assign in_stall_o       = (state_q != StIdle);
  assign filtered_angle_o = out_q;

  `KAF_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, in_stall_o, "accept while busy")
  `KAF_ASSERT_NEXT(a_out_after_seq, clk_i, rst_ni, state_q == StOut, out_valid_o, "result lost")
  `KAF_ASSERT_IMP(a_div_idle_start, clk_i, rst_ni, div_req.start, state_q == StDiv, "stray divide")
endmodule
